// ===== rtl/core/sscu_pkg.sv =====
// Shared types and constants for the sparse-set component table.
// Holds the request/response structs, operation and status codes and the FSM states.
// No dependencies.
package sscu_pkg;

  // fixed field widths of the request and response items
  localparam int unsigned ENTITY_W = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 9;

  // default sizing of the table
  localparam int unsigned MAX_IDS_DEF    = 1024;
  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // operation codes
  typedef enum logic [1:0] {
    FN_ADD       = 2'd0,
    FN_REMOVE    = 2'd1,
    FN_LOOKUP    = 2'd2,
    FN_SLOT_READ = 2'd3
  } func_t;

  // response status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_READ,
    S_MOVE
  } state_t;

  typedef struct packed {
    func_t               func;
    logic [ENTITY_W-1:0] entity;
    logic [VALUE_W-1:0]  value;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [VALUE_W-1:0]  value_out;
    logic [ENTITY_W-1:0] owner_out;
    logic [SLOT_W-1:0]   slot_out;
    logic [COUNT_W-1:0]  count_out;
  } rsp_t;

endpackage

// ===== rtl/core/sscu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Parameterized by word width and depth; no package dependency.
module sscu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sscu_rsp_buf.sv =====
// Response output register with one spare entry, so a finished result can wait
// while the next request is taken. Uses sscu_pkg for the response struct.
module sscu_rsp_buf
  import sscu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  rsp_t load_data,
  output logic spare_full,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready
);

  rsp_t spare;
  logic spare_valid;
  logic take;

  // output register can take a new entry this cycle
  assign take       = !rsp_valid || rsp_ready;
  assign spare_full = spare_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (load) begin
      if (take) begin
        rsp_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (spare_valid && take) begin
      rsp_valid   <= 1'b1;
      spare_valid <= 1'b0;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      if (take) begin
        rsp <= load_data;
      end else begin
        spare <= load_data;
      end
    end else if (spare_valid && take) begin
      rsp <= spare;
    end
  end

endmodule

// ===== rtl/core/sparse_set_component_table_unit.sv =====
// Sparse-set component table: id map, packed dense store and entry count.
// Depends on sscu_pkg, sscu_ram and sscu_rsp_buf.
//
// Usage:
//   Requests arrive on req/req_valid/req_ready, one operation per transfer:
//   add or update, remove (swap with last entry), lookup by id, read by slot.
//   Each request gives exactly one response on rsp/rsp_valid/rsp_ready.
//   After reset the id map is swept clear, one entry per cycle, so req_ready
//   stays low until all MAX_IDS entries (1024 by default) are clear; then it rises.
//   Add and slot read finish in S_LOOK; lookup runs on through S_READ and
//   remove through S_MOVE, and either finishes in S_LOOK when the id is
//   absent. One operation is in flight at a time; the next request is
//   taken only once the unit is back in S_IDLE, since each operation walks
//   in turn through the map and dense RAMs, whose read data is registered.
//   A response the receiver has not taken sits in the output register and
//   a spare entry holds the next one; apart from the clear sweep and the
//   operation in flight, req_ready drops only while the spare entry is occupied.
module sparse_set_component_table_unit
  import sscu_pkg::*;
#(
  parameter int unsigned MAX_IDS    = MAX_IDS_DEF,
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_ready,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready
);

  localparam int unsigned MAP_AW  = $clog2(MAX_IDS);
  localparam int unsigned POS_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned MAP_W   = POS_W + 1;
  localparam int unsigned DENSE_W = ENTITY_W + VALUE_BITS;

  state_t state, state_next;

  req_t               op;
  logic [CNT_W-1:0]   count, count_next;
  logic [POS_W-1:0]   pos;
  logic [MAP_AW-1:0]  clr_addr;

  // map port signals: entry is {valid, slot}
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr, map_raddr;
  logic [MAP_W-1:0]   map_wdata, map_rdata;

  // dense port signals: entry is {owner, value}
  logic               dense_we;
  logic [POS_W-1:0]   dense_waddr, dense_raddr;
  logic [DENSE_W-1:0] dense_wdata, dense_rdata;
  logic [ENTITY_W-1:0]   rd_owner;
  logic [VALUE_BITS-1:0] rd_value;

  logic               in_map, present, spare_full, done, accept;
  logic [POS_W-1:0]   map_pos;
  rsp_t               res;

  sscu_ram #(.WIDTH(MAP_W), .DEPTH(MAX_IDS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  sscu_ram #(.WIDTH(DENSE_W), .DEPTH(CAPACITY)) u_dense_ram (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

  sscu_rsp_buf u_rsp_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (done),
    .load_data  (res),
    .spare_full (spare_full),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready)
  );

  // request handshake
  assign req_ready = (state == S_IDLE) && !spare_full;
  assign accept    = req_valid && req_ready;

  // decode of the map entry read for the latched request
  assign in_map   = 32'(op.entity) < 32'(MAX_IDS);
  assign present  = in_map && map_rdata[MAP_W-1];
  assign map_pos  = map_rdata[POS_W-1:0];
  assign rd_owner = dense_rdata[DENSE_W-1 -: ENTITY_W];
  assign rd_value = dense_rdata[VALUE_BITS-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == MAP_AW'(MAX_IDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (present && op.func == FN_REMOVE) begin
          state_next = S_MOVE;
        end else if (present && op.func == FN_LOOKUP) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: state_next = S_IDLE;
      S_MOVE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory accesses, count update and response
  always_comb begin
    map_we      = 1'b0;
    map_waddr   = MAP_AW'(op.entity);
    map_wdata   = '0;
    map_raddr   = MAP_AW'(req.entity);
    dense_we    = 1'b0;
    dense_waddr = map_pos;
    dense_wdata = {op.entity, VALUE_BITS'(op.value)};
    dense_raddr = POS_W'(req.slot);
    count_next  = count;
    done        = 1'b0;
    res         = '0;
    res.status  = STAT_ABSENT;

    unique case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
      end
      S_IDLE: begin
      end
      S_LOOK: begin
        unique case (op.func)
          FN_ADD: begin
            done = 1'b1;
            if (present) begin
              // overwrite in place, the owner is this id already
              dense_we     = 1'b1;
              res.status   = STAT_OK;
              res.found    = 1'b1;
              res.slot_out = SLOT_W'(map_pos);
            end else if (!in_map) begin
              res.status = STAT_ABSENT;
            end else if (count == CNT_W'(CAPACITY)) begin
              res.status = STAT_FULL;
            end else begin
              // append at the end of the dense store
              dense_we     = 1'b1;
              dense_waddr  = POS_W'(count);
              map_we       = 1'b1;
              map_wdata    = {1'b1, POS_W'(count)};
              count_next   = count + CNT_W'(1);
              res.status   = STAT_OK;
              res.slot_out = SLOT_W'(count);
            end
          end
          FN_REMOVE: begin
            if (present) begin
              // drop the id now and fetch the last entry
              map_we      = 1'b1;
              dense_raddr = POS_W'(count - CNT_W'(1));
            end else begin
              done = 1'b1;
            end
          end
          FN_LOOKUP: begin
            if (present) begin
              dense_raddr = map_pos;
            end else begin
              done = 1'b1;
            end
          end
          FN_SLOT_READ: begin
            done = 1'b1;
            if (CNT_W'(op.slot) < count && 32'(op.slot) < 32'(CAPACITY)) begin
              res.status    = STAT_OK;
              res.found     = 1'b1;
              res.value_out = VALUE_W'(rd_value);
              res.owner_out = rd_owner;
              res.slot_out  = op.slot;
            end
          end
          default: done = 1'b1;
        endcase
      end
      S_READ: begin
        done          = 1'b1;
        res.status    = STAT_OK;
        res.found     = 1'b1;
        res.value_out = VALUE_W'(rd_value);
        res.slot_out  = SLOT_W'(pos);
      end
      S_MOVE: begin
        // last entry fills the hole and its map entry follows it
        done        = 1'b1;
        dense_we    = 1'b1;
        dense_waddr = pos;
        dense_wdata = dense_rdata;
        if (rd_owner != op.entity) begin
          map_we    = 1'b1;
          map_waddr = MAP_AW'(rd_owner);
          map_wdata = {1'b1, pos};
        end
        count_next   = count - CNT_W'(1);
        res.status   = STAT_OK;
        res.found    = 1'b1;
        res.slot_out = SLOT_W'(pos);
      end
      default: begin
      end
    endcase
    res.count_out = COUNT_W'(count_next);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + MAP_AW'(1);
    end
  end

  // request and slot holding registers
  always_ff @(posedge clk) begin
    if (accept) op <= req;
    if (state == S_LOOK) pos <= map_pos;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sparse-set component table unit.
// Holds the prediction scoreboard class, the request and response drivers and the run sequence.
// Depends on sscu_pkg and the sparse_set_component_table_unit RTL.
module testbench
  import sscu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 10;

  // predicted table state and the queue of responses still owed
  class table_scoreboard;
    logic [COUNT_W-1:0]  id_map [MAX_IDS_DEF];
    logic [VALUE_W-1:0]  dense_value [CAPACITY_DEF];
    logic [ENTITY_W-1:0] dense_owner [CAPACITY_DEF];
    int unsigned         count;
    rsp_t                owed_rsps [$];
    int unsigned         failures;
    int unsigned         checked;

    function new();
      foreach (id_map[i]) id_map[i] = '0;
      count    = 0;
      failures = 0;
      checked  = 0;
    endfunction

    // apply one accepted request to the predicted table
    function void note_request(req_t r);
      rsp_t               want;
      logic [COUNT_W-1:0] entry;
      logic               present;
      int unsigned        pos;
      int unsigned        last;
      logic [ENTITY_W-1:0] mover;
      want        = '0;
      want.status = STAT_ABSENT;
      entry       = id_map[r.entity];
      present     = (entry != '0);
      pos         = present ? int'(entry) - 1 : 0;
      case (r.func)
        FN_ADD: begin
          if (present) begin
            dense_value[pos] = r.value;
            want.status      = STAT_OK;
            want.found       = 1'b1;
            want.slot_out    = SLOT_W'(pos);
          end else if (count >= CAPACITY_DEF) begin
            want.status = STAT_FULL;
          end else begin
            pos                = count;
            dense_value[pos]   = r.value;
            dense_owner[pos]   = r.entity;
            id_map[r.entity]   = COUNT_W'(pos + 1);
            count              = pos + 1;
            want.status        = STAT_OK;
            want.slot_out      = SLOT_W'(pos);
          end
        end
        FN_REMOVE: begin
          // swap the last entry into the hole, then drop the id
          if (present && count > 0) begin
            last             = count - 1;
            dense_value[pos] = dense_value[last];
            dense_owner[pos] = dense_owner[last];
            mover            = dense_owner[pos];
            id_map[mover]    = COUNT_W'(pos + 1);
            id_map[r.entity] = '0;
            count            = last;
            want.status      = STAT_OK;
            want.found       = 1'b1;
            want.slot_out    = SLOT_W'(pos);
          end
        end
        FN_LOOKUP: begin
          if (present) begin
            want.status    = STAT_OK;
            want.found     = 1'b1;
            want.value_out = dense_value[pos];
            want.slot_out  = SLOT_W'(pos);
          end
        end
        FN_SLOT_READ: begin
          if (r.slot < count) begin
            want.status    = STAT_OK;
            want.found     = 1'b1;
            want.value_out = dense_value[r.slot];
            want.owner_out = dense_owner[r.slot];
            want.slot_out  = r.slot;
          end
        end
      endcase
      want.count_out = COUNT_W'(count);
      owed_rsps.insert(owed_rsps.size(), want);
    endfunction

    // compare one response transfer with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (owed_rsps.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("response %0d arrived with nothing owed: %p", checked, got);
        return;
      end
      want = owed_rsps.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.value_out !== want.value_out || got.owner_out !== want.owner_out ||
          got.slot_out !== want.slot_out || got.count_out !== want.count_out) begin
        failures++;
        if (failures <= 10) begin
          $display("response %0d mismatch", checked);
          $display("  exp status %0d found %0d value %h owner %0d slot %0d count %0d",
                   want.status, want.found, want.value_out, want.owner_out,
                   want.slot_out, want.count_out);
          $display("  got status %0d found %0d value %h owner %0d slot %0d count %0d",
                   got.status, got.found, got.value_out, got.owner_out,
                   got.slot_out, got.count_out);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_rsps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_ready = 1'b0;

  table_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  sparse_set_component_table_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  always #1 clk = ~clk;

  // response side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // watchdog on total run length
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // offer one request, with random idle cycles first, until it transfers
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  function automatic req_t make_req(func_t f, int unsigned ent, logic [VALUE_W-1:0] val,
                                    int unsigned sl);
    req_t r;
    r.func   = f;
    r.entity = ENTITY_W'(ent);
    r.value  = val;
    r.slot   = SLOT_W'(sl);
    return r;
  endfunction

  // random request, steered toward ids and slots that are live in the table
  function automatic req_t make_random_req(int unsigned add_pct, int unsigned rm_pct);
    req_t        r;
    int unsigned live;
    int unsigned roll;
    int unsigned top;
    live = sb.count;
    roll = $urandom_range(0, 99);
    r.entity = ($urandom_range(0, 9) == 0) ? ENTITY_W'($urandom_range(0, 1023))
                                            : ENTITY_W'($urandom_range(0, 511));
    case ($urandom_range(0, 19))
      0:       r.value = '1;
      1:       r.value = '0;
      default: r.value = $urandom();
    endcase
    r.slot = SLOT_W'($urandom_range(0, 255));
    if (roll < add_pct) begin
      r.func = FN_ADD;
      if (live > 0 && $urandom_range(0, 99) < 15)
        r.entity = sb.dense_owner[$urandom_range(0, live - 1)];
    end else if (roll < add_pct + rm_pct) begin
      r.func = FN_REMOVE;
      if (live > 0 && $urandom_range(0, 99) < 80)
        r.entity = sb.dense_owner[$urandom_range(0, live - 1)];
    end else if (roll < add_pct + rm_pct + (100 - add_pct - rm_pct) / 2) begin
      r.func = FN_LOOKUP;
      if (live > 0 && $urandom_range(0, 99) < 60)
        r.entity = sb.dense_owner[$urandom_range(0, live - 1)];
    end else begin
      r.func = FN_SLOT_READ;
      top = (live + 2 > 255) ? 255 : live + 2;
      if ($urandom_range(0, 99) < 80) r.slot = SLOT_W'($urandom_range(0, top));
    end
    return r;
  endfunction

  task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall,
                           int unsigned add_pct, int unsigned rm_pct);
    send_idle_pct = idle;
    rsp_stall_pct = stall;
    repeat (n) send_request(make_random_req(add_pct, rm_pct));
  endtask

  // main sequence: reset, directed cases, random phases, drain
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table: absent lookup, remove and slot read
    send_request(make_req(FN_LOOKUP, 0, '0, 0));
    send_request(make_req(FN_REMOVE, 5, '0, 0));
    send_request(make_req(FN_SLOT_READ, 0, '0, 0));
    // appends at the id extremes, then an update in place
    send_request(make_req(FN_ADD, 0, '0, 0));
    send_request(make_req(FN_ADD, 1023, '1, 0));
    send_request(make_req(FN_ADD, 0, 32'h1234_5678, 0));
    send_request(make_req(FN_LOOKUP, 0, '0, 0));
    send_request(make_req(FN_LOOKUP, 1023, '0, 0));
    send_request(make_req(FN_LOOKUP, 1, '0, 0));
    // slot reads inside and beyond the count
    send_request(make_req(FN_SLOT_READ, 0, '0, 0));
    send_request(make_req(FN_SLOT_READ, 0, '0, 1));
    send_request(make_req(FN_SLOT_READ, 0, '0, 2));
    send_request(make_req(FN_SLOT_READ, 0, '0, 255));
    // remove from the middle moves the last entry into the hole
    send_request(make_req(FN_ADD, 512, 32'ha5a5_a5a5, 0));
    send_request(make_req(FN_REMOVE, 0, '0, 0));
    send_request(make_req(FN_LOOKUP, 512, '0, 0));
    send_request(make_req(FN_SLOT_READ, 0, '0, 0));
    // remove of the last entry moves it onto itself
    send_request(make_req(FN_REMOVE, 1023, '0, 0));
    send_request(make_req(FN_REMOVE, 1023, '0, 0));
    send_request(make_req(FN_LOOKUP, 1023, '0, 0));
    send_request(make_req(FN_REMOVE, 512, '0, 0));
    send_request(make_req(FN_SLOT_READ, 0, '0, 0));
    send_request(make_req(FN_ADD, 341, 32'h5a5a_5a5a, 0));
    send_request(make_req(FN_ADD, 682, '0, 0));

    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    run_phase(200, 0, 0, 35, 25);
    // fill toward capacity, then churn while full, then drain
    run_phase(450, 87, 0, 90, 0);
    run_phase(250, 0, 87, 40, 30);
    run_phase(350, 32, 32, 5, 80);
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sscu_pkg.sv
rtl/core/sscu_ram.sv
rtl/core/sscu_rsp_buf.sv
rtl/core/sparse_set_component_table_unit.sv
tb/sv/testbench.sv
